// ===== rtl/drfd_pkg.sv =====
`default_nettype none

package drfd_pkg;

   localparam int MAX_CLASSES_DEFAULT = 256;

   localparam int VALUE_W = 20;
   localparam int SCORE_W = 16;
   localparam int CLASS_W = 9;
   localparam int PAD_W = 12;
   localparam int INV_W = 24;
   localparam int DIM_W = 13;
   localparam int NUM_W = 23;
   localparam int MAG_W = 22;
   localparam int UNS_W = 21;
   localparam int UNS_SHIFT = 25;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_CLASSES = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONF_THRESHOLD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_X = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_Y = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_SCALE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 3'd6;

   localparam logic [8:0] NUM_CLASSES_RESET = 9'd80;
   localparam logic [15:0] CONF_THRESHOLD_RESET = 16'd32768;
   localparam logic [11:0] PAD_RESET = 12'd0;
   localparam logic [23:0] INV_SCALE_RESET = 24'd65536;
   localparam logic [12:0] FRAME_WIDTH_RESET = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 80;

   localparam int LANES = 4;
   localparam int LANE_X1 = 0;
   localparam int LANE_X2 = 1;
   localparam int LANE_Y1 = 2;
   localparam int LANE_Y2 = 3;

endpackage

`default_nettype wire

// ===== rtl/detection_row_filter_decode_top.sv =====
// Detection row filter and decoder.
// The request stream (req_) carries one detector tensor element per request: the
// element in req_tdata, a frame start flag in req_tuser and the frame end flag in
// req_tlast. Each row is cx, cy, w, h, objectness and then num_classes scores.
// The response stream (rsp_) carries one result per kept box or frame end (one if
// both meet); tuser marks a result that carries a box and tlast ends the frame.
// The block takes one request per clock cycle unless a stalled receiver holds it.
// A response passes a row register, an offset stage, a stage of four 22 by 24 bit
// multipliers and the result register after its row's last element is accepted.
// The csr_ port writes a register at any edge with csr_wr_en high; the user must
// write it only while no request is in flight; the block does not enforce this.
// Synchronous reset loads the register defaults, clears the row position and
// empties the pipeline. No warm-up pass is needed.
// When the receiver stalls, the result register holds its response and the
// stages behind it keep taking requests until they are full, then req_tready
// drops.
`default_nettype none

module detection_row_filter_decode_top #(
   parameter int MAX_CLASSES = drfd_pkg::MAX_CLASSES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // Bits from the lowest up: value (20), zero fill (4).
   input  wire logic [drfd_pkg::REQ_DATA_W-1:0] req_tdata,
   // Bits from the lowest up: frame_start (1).
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // Bits from the lowest up: class_id (9), confidence (16), box_x (13), box_y (13),
   // box_w (13), box_h (13), zero fill (3).
   output logic [drfd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Bits from the lowest up: box_valid (1).
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_wr_en,
   input  wire logic [drfd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [drfd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW = $clog2(MAX_CLASSES + 5);

   function automatic logic [drfd_pkg::SCORE_W-1:0] sat16(
      input logic [drfd_pkg::VALUE_W-1:0] v
   );
      sat16 = (v[drfd_pkg::VALUE_W-1:drfd_pkg::SCORE_W] != '0) ? '1 :
              v[drfd_pkg::SCORE_W-1:0];
   endfunction

   function automatic logic signed [drfd_pkg::NUM_W-1:0] numer(
      input logic [drfd_pkg::VALUE_W-1:0] c,
      input logic [drfd_pkg::VALUE_W-1:0] s,
      input logic [drfd_pkg::PAD_W-1:0]   pad,
      input logic                         add
   );
      logic signed [drfd_pkg::NUM_W-1:0] c2;
      logic signed [drfd_pkg::NUM_W-1:0] se;
      logic signed [drfd_pkg::NUM_W-1:0] pe;
      c2 = $signed({2'b0, c, 1'b0});
      se = $signed({3'b0, s});
      pe = $signed({2'b0, pad, 9'b0});
      numer = add ? (c2 + se - pe) : (c2 - se - pe);
   endfunction

   function automatic logic signed [drfd_pkg::NUM_W-1:0] resign(
      input logic                         neg,
      input logic [drfd_pkg::UNS_W-1:0]   mag
   );
      logic signed [drfd_pkg::NUM_W-1:0] m;
      m = $signed({2'b0, mag});
      resign = neg ? -m : m;
   endfunction

   // Configuration registers.
   logic [8:0]                       num_classes_ff;
   logic [drfd_pkg::SCORE_W-1:0]     conf_threshold_ff;
   logic [drfd_pkg::PAD_W-1:0]       pad_x_ff;
   logic [drfd_pkg::PAD_W-1:0]       pad_y_ff;
   logic [drfd_pkg::INV_W-1:0]       inv_scale_ff;
   logic [drfd_pkg::DIM_W-1:0]       frame_width_ff;
   logic [drfd_pkg::DIM_W-1:0]       frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= drfd_pkg::NUM_CLASSES_RESET;
         conf_threshold_ff <= drfd_pkg::CONF_THRESHOLD_RESET;
         pad_x_ff <= drfd_pkg::PAD_RESET;
         pad_y_ff <= drfd_pkg::PAD_RESET;
         inv_scale_ff <= drfd_pkg::INV_SCALE_RESET;
         frame_width_ff <= drfd_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= drfd_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            drfd_pkg::CSR_NUM_CLASSES: num_classes_ff <= csr_wdata[8:0];
            drfd_pkg::CSR_CONF_THRESHOLD: conf_threshold_ff <= csr_wdata[15:0];
            drfd_pkg::CSR_PAD_X: pad_x_ff <= csr_wdata[11:0];
            drfd_pkg::CSR_PAD_Y: pad_y_ff <= csr_wdata[11:0];
            drfd_pkg::CSR_INV_SCALE: inv_scale_ff <= csr_wdata[23:0];
            drfd_pkg::CSR_FRAME_WIDTH: frame_width_ff <= csr_wdata[12:0];
            drfd_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Pipeline handshake.
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic out_free, c_ready, b_ready, a_ready, req_fire;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign c_ready = !c_valid_ff || out_free;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign req_fire = req_tvalid && a_ready;

   // Row state.
   logic [PW-1:0]                    row_pos_ff, row_pos_in;
   logic [drfd_pkg::VALUE_W-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [drfd_pkg::VALUE_W-1:0]     bw_ff, bw_in, bh_ff, bh_in;
   logic [drfd_pkg::SCORE_W-1:0]     obj_ff, obj_in, best_ff, best_in;
   logic [drfd_pkg::CLASS_W-1:0]     cls_ff, cls_in;
   logic [PW-1:0]                    pos;
   logic [PW-1:0]                    nc_eff;
   logic [drfd_pkg::VALUE_W-1:0]     value;
   logic [drfd_pkg::SCORE_W-1:0]     score;
   logic                             row_end;

   assign value = req_tdata[drfd_pkg::VALUE_W-1:0];
   assign score = sat16(value);
   assign pos = req_tuser ? '0 : row_pos_ff;

   always_comb begin
      if (num_classes_ff == '0) begin
         nc_eff = PW'(1);
      end else if (int'(num_classes_ff) > MAX_CLASSES) begin
         nc_eff = PW'(MAX_CLASSES);
      end else begin
         nc_eff = PW'(num_classes_ff);
      end
   end

   assign row_end = (pos >= PW'(5)) &&
                    ({1'b0, pos} >= ({1'b0, nc_eff} + (PW+1)'(4)));

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      bw_in = bw_ff;
      bh_in = bh_ff;
      obj_in = obj_ff;
      best_in = best_ff;
      cls_in = cls_ff;
      case (pos)
         PW'(0): cx_in = value;
         PW'(1): cy_in = value;
         PW'(2): bw_in = value;
         PW'(3): bh_in = value;
         PW'(4): begin
            obj_in = score;
            best_in = '0;
            cls_in = '1;
         end
         default: begin
            if (score > best_ff) begin
               best_in = score;
               cls_in = drfd_pkg::CLASS_W'(pos - PW'(5));
            end
         end
      endcase
      if (req_tlast || row_end) begin
         row_pos_in = '0;
      end else begin
         row_pos_in = pos + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         cx_ff <= '0;
         cy_ff <= '0;
         bw_ff <= '0;
         bh_ff <= '0;
         obj_ff <= '0;
         best_ff <= '0;
         cls_ff <= '1;
      end else if (req_fire) begin
         row_pos_ff <= row_pos_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         bw_ff <= bw_in;
         bh_ff <= bh_in;
         obj_ff <= obj_in;
         best_ff <= best_in;
         cls_ff <= cls_in;
      end
   end

   // Stage A: finished row or frame end.
   logic                             a_row_ff, a_fend_ff;
   logic [drfd_pkg::VALUE_W-1:0]     a_cx_ff, a_cy_ff, a_bw_ff, a_bh_ff;
   logic [drfd_pkg::SCORE_W-1:0]     a_obj_ff, a_best_ff;
   logic [drfd_pkg::CLASS_W-1:0]     a_cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_fire && (row_end || req_tlast);
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_row_ff <= row_end;
         a_fend_ff <= req_tlast;
         a_cx_ff <= cx_in;
         a_cy_ff <= cy_in;
         a_bw_ff <= bw_in;
         a_bh_ff <= bh_in;
         a_obj_ff <= obj_in;
         a_best_ff <= best_in;
         a_cls_ff <= cls_in;
      end
   end

   // Stage B: box edges relative to padding, confidence product.
   logic                             b_row_ff, b_fend_ff, b_obj_ok_ff;
   logic [31:0]                      b_conf_ff;
   logic [drfd_pkg::CLASS_W-1:0]     b_cls_ff;
   logic [drfd_pkg::LANES-1:0]       b_neg_ff;
   logic [drfd_pkg::MAG_W-1:0]       b_mag_ff [drfd_pkg::LANES];
   logic signed [drfd_pkg::NUM_W-1:0] a_num [drfd_pkg::LANES];
   logic [19:0]                      a_obj10;

   assign a_num[drfd_pkg::LANE_X1] = numer(a_cx_ff, a_bw_ff, pad_x_ff, 1'b0);
   assign a_num[drfd_pkg::LANE_X2] = numer(a_cx_ff, a_bw_ff, pad_x_ff, 1'b1);
   assign a_num[drfd_pkg::LANE_Y1] = numer(a_cy_ff, a_bh_ff, pad_y_ff, 1'b0);
   assign a_num[drfd_pkg::LANE_Y2] = numer(a_cy_ff, a_bh_ff, pad_y_ff, 1'b1);
   assign a_obj10 = {1'b0, a_obj_ff, 3'b0} + {3'b0, a_obj_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_row_ff <= a_row_ff;
         b_fend_ff <= a_fend_ff;
         b_cls_ff <= a_cls_ff;
         b_obj_ok_ff <= a_obj10 >= {4'b0, conf_threshold_ff};
         b_conf_ff <= {16'b0, a_obj_ff} * {16'b0, a_best_ff};
         for (int i = 0; i < drfd_pkg::LANES; i++) begin
            b_neg_ff[i] <= a_num[i][drfd_pkg::NUM_W-1];
            b_mag_ff[i] <= a_num[i][drfd_pkg::NUM_W-1] ?
                           drfd_pkg::MAG_W'(-a_num[i]) : drfd_pkg::MAG_W'(a_num[i]);
         end
      end
   end

   // Stage C: multiply by the reciprocal scale.
   logic                             c_keep_ff, c_fend_ff;
   logic [drfd_pkg::SCORE_W-1:0]     c_conf_ff;
   logic [drfd_pkg::CLASS_W-1:0]     c_cls_ff;
   logic [drfd_pkg::LANES-1:0]       c_neg_ff;
   logic [drfd_pkg::UNS_W-1:0]       c_mag_ff [drfd_pkg::LANES];
   logic [drfd_pkg::MAG_W+drfd_pkg::INV_W-1:0] b_prod [drfd_pkg::LANES];

   always_comb begin
      for (int i = 0; i < drfd_pkg::LANES; i++) begin
         b_prod[i] = {{drfd_pkg::INV_W{1'b0}}, b_mag_ff[i]} *
                     {{drfd_pkg::MAG_W{1'b0}}, inv_scale_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_fend_ff <= b_fend_ff;
         c_cls_ff <= b_cls_ff;
         c_conf_ff <= b_conf_ff[31:16];
         c_keep_ff <= b_row_ff && b_obj_ok_ff && (b_conf_ff[31:16] >= conf_threshold_ff);
         c_neg_ff <= b_neg_ff;
         for (int i = 0; i < drfd_pkg::LANES; i++) begin
            c_mag_ff[i] <= b_prod[i][drfd_pkg::UNS_SHIFT+drfd_pkg::UNS_W-1:drfd_pkg::UNS_SHIFT];
         end
      end
   end

   // Result: clip to the frame.
   logic signed [drfd_pkg::NUM_W-1:0] x1, x2, y1, y2, bx1, bx2, by1, by2;
   logic signed [drfd_pkg::NUM_W-1:0] fw_s, fh_s, dw, dh;
   logic                             box_ok;

   assign x1 = resign(c_neg_ff[drfd_pkg::LANE_X1], c_mag_ff[drfd_pkg::LANE_X1]);
   assign x2 = resign(c_neg_ff[drfd_pkg::LANE_X2], c_mag_ff[drfd_pkg::LANE_X2]);
   assign y1 = resign(c_neg_ff[drfd_pkg::LANE_Y1], c_mag_ff[drfd_pkg::LANE_Y1]);
   assign y2 = resign(c_neg_ff[drfd_pkg::LANE_Y2], c_mag_ff[drfd_pkg::LANE_Y2]);
   assign fw_s = $signed({10'b0, frame_width_ff});
   assign fh_s = $signed({10'b0, frame_height_ff});
   assign bx1 = (x1 < 0) ? '0 : x1;
   assign by1 = (y1 < 0) ? '0 : y1;
   assign bx2 = (x2 > fw_s) ? fw_s : x2;
   assign by2 = (y2 > fh_s) ? fh_s : y2;
   assign dw = bx2 - bx1;
   assign dh = by2 - by1;
   assign box_ok = c_keep_ff && (bx2 > bx1) && (by2 > by1);

   logic                             out_box_ff, out_done_ff;
   logic [drfd_pkg::CLASS_W-1:0]     out_cls_ff;
   logic [drfd_pkg::SCORE_W-1:0]     out_conf_ff;
   logic [drfd_pkg::DIM_W-1:0]       out_x_ff, out_y_ff, out_w_ff, out_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= c_valid_ff && (box_ok || c_fend_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_box_ff <= box_ok;
         out_done_ff <= c_fend_ff;
         out_cls_ff <= box_ok ? c_cls_ff : '0;
         out_conf_ff <= box_ok ? c_conf_ff : '0;
         out_x_ff <= box_ok ? bx1[drfd_pkg::DIM_W-1:0] : '0;
         out_y_ff <= box_ok ? by1[drfd_pkg::DIM_W-1:0] : '0;
         out_w_ff <= box_ok ? dw[drfd_pkg::DIM_W-1:0] : '0;
         out_h_ff <= box_ok ? dh[drfd_pkg::DIM_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = out_box_ff;
   assign rsp_tlast = out_done_ff;
   assign rsp_tdata = {3'b0, out_h_ff, out_w_ff, out_y_ff, out_x_ff, out_conf_ff, out_cls_ff};

endmodule

`default_nettype wire

// ===== rtl/drfd_checker.sv =====
`default_nettype none

module drfd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [drfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser,
   input wire logic                            rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_no_box_is_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("response without a box is not a clean frame end");

   a_box_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[63:51] != '0) && (rsp_tdata[76:64] != '0))
      else $error("kept box is empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind detection_row_filter_decode_top drfd_checker u_drfd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

`default_nettype wire

// ===== bench/detection_result_checker.sv =====
`default_nettype none

module detection_result_checker #(
   parameter int MAX_CLASSES = drfd_pkg::MAX_CLASSES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [drfd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [drfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            rsp_tuser,
   input  wire logic                            rsp_tlast,
   input  wire logic                            csr_wr_en,
   input  wire logic [drfd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [drfd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                   fail_count,
   output int                                   open_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                           box_valid;
      logic [drfd_pkg::CLASS_W-1:0]   class_id;
      logic [drfd_pkg::SCORE_W-1:0]   confidence;
      logic [drfd_pkg::DIM_W-1:0]     box_x;
      logic [drfd_pkg::DIM_W-1:0]     box_y;
      logic [drfd_pkg::DIM_W-1:0]     box_w;
      logic [drfd_pkg::DIM_W-1:0]     box_h;
      logic                           frame_done;
   } detection_type;

   logic [8:0]                   num_classes;
   logic [15:0]                  conf_threshold;
   logic [drfd_pkg::PAD_W-1:0]   pad_x;
   logic [drfd_pkg::PAD_W-1:0]   pad_y;
   logic [drfd_pkg::INV_W-1:0]   inv_scale;
   logic [drfd_pkg::DIM_W-1:0]   frame_width;
   logic [drfd_pkg::DIM_W-1:0]   frame_height;

   logic [8:0]                   row_pos;
   logic [drfd_pkg::VALUE_W-1:0] center_x;
   logic [drfd_pkg::VALUE_W-1:0] center_y;
   logic [drfd_pkg::VALUE_W-1:0] width_in;
   logic [drfd_pkg::VALUE_W-1:0] height_in;
   logic [drfd_pkg::SCORE_W-1:0] objectness;
   logic [drfd_pkg::SCORE_W-1:0] best_score;
   logic [drfd_pkg::CLASS_W-1:0] best_class;

   detection_type expected_dets[$];

   function automatic longint unscale_coord(input longint num);
      longint unsigned mag;
      mag = (num < 0) ? -num : num;
      mag = (mag * inv_scale) >> drfd_pkg::UNS_SHIFT;
      return (num < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic void decode_element(input logic [drfd_pkg::VALUE_W-1:0] v,
                                          input logic fs, input logic fe);
      int unsigned                  nc;
      logic [drfd_pkg::SCORE_W-1:0] s;
      logic                         accepted;
      logic [drfd_pkg::SCORE_W-1:0] conf;
      longint                       x1, x2, y1, y2;
      longint                       bx1, by1, bx2, by2;
      detection_type                d;
      nc = num_classes;
      if (nc == 0) nc = 1;
      if (nc > MAX_CLASSES) nc = MAX_CLASSES;
      accepted = 1'b0;
      conf = '0;
      bx1 = 0;
      by1 = 0;
      bx2 = 0;
      by2 = 0;
      s = (v > 20'd65535) ? 16'hFFFF : v[drfd_pkg::SCORE_W-1:0];
      if (fs) row_pos = '0;
      case (row_pos)
         9'd0: center_x = v;
         9'd1: center_y = v;
         9'd2: width_in = v;
         9'd3: height_in = v;
         9'd4: begin
            objectness = s;
            best_score = '0;
            best_class = '1;
         end
         default: begin
            if (s > best_score) begin
               best_score = s;
               best_class = row_pos - 9'd5;
            end
         end
      endcase
      if (row_pos >= 5 && row_pos >= 4 + nc) begin
         row_pos = '0;
         conf = 16'((32'(objectness) * 32'(best_score)) >> 16);
         if (10 * int'(objectness) >= int'(conf_threshold) && conf >= conf_threshold) begin
            x1 = unscale_coord(2 * longint'(center_x) - longint'(width_in)
                               - 512 * longint'(pad_x));
            x2 = unscale_coord(2 * longint'(center_x) + longint'(width_in)
                               - 512 * longint'(pad_x));
            y1 = unscale_coord(2 * longint'(center_y) - longint'(height_in)
                               - 512 * longint'(pad_y));
            y2 = unscale_coord(2 * longint'(center_y) + longint'(height_in)
                               - 512 * longint'(pad_y));
            bx1 = (x1 < 0) ? 0 : x1;
            by1 = (y1 < 0) ? 0 : y1;
            bx2 = (x2 > longint'(frame_width)) ? longint'(frame_width) : x2;
            by2 = (y2 > longint'(frame_height)) ? longint'(frame_height) : y2;
            accepted = (bx2 > bx1) && (by2 > by1);
         end
      end else begin
         row_pos = row_pos + 9'd1;
      end
      if (fe) row_pos = '0;
      if (accepted || fe) begin
         d = '0;
         if (accepted) begin
            d.box_valid = 1'b1;
            d.class_id = best_class;
            d.confidence = conf;
            d.box_x = bx1[drfd_pkg::DIM_W-1:0];
            d.box_y = by1[drfd_pkg::DIM_W-1:0];
            d.box_w = drfd_pkg::DIM_W'(bx2 - bx1);
            d.box_h = drfd_pkg::DIM_W'(by2 - by1);
         end
         d.frame_done = fe;
         expected_dets = {expected_dets, d};
      end
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void compare_result();
      detection_type got;
      detection_type want;
      got.box_valid = rsp_tuser;
      got.class_id = rsp_tdata[8:0];
      got.confidence = rsp_tdata[24:9];
      got.box_x = rsp_tdata[37:25];
      got.box_y = rsp_tdata[50:38];
      got.box_w = rsp_tdata[63:51];
      got.box_h = rsp_tdata[76:64];
      got.frame_done = rsp_tlast;
      if (expected_dets.size() == 0) begin
         $error("unexpected result: box_valid %0b class_id %0d frame_done %0b",
                got.box_valid, $signed(got.class_id), got.frame_done);
         fail_count++;
      end else begin
         want = expected_dets.pop_front();
         check_field("box_valid", want.box_valid, got.box_valid);
         check_field("class_id", $signed(want.class_id), $signed(got.class_id));
         check_field("confidence", want.confidence, got.confidence);
         check_field("box_x", want.box_x, got.box_x);
         check_field("box_y", want.box_y, got.box_y);
         check_field("box_w", want.box_w, got.box_w);
         check_field("box_h", want.box_h, got.box_h);
         check_field("frame_done", want.frame_done, got.frame_done);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         num_classes = drfd_pkg::NUM_CLASSES_RESET;
         conf_threshold = drfd_pkg::CONF_THRESHOLD_RESET;
         pad_x = drfd_pkg::PAD_RESET;
         pad_y = drfd_pkg::PAD_RESET;
         inv_scale = drfd_pkg::INV_SCALE_RESET;
         frame_width = drfd_pkg::FRAME_WIDTH_RESET;
         frame_height = drfd_pkg::FRAME_HEIGHT_RESET;
         row_pos = '0;
         center_x = '0;
         center_y = '0;
         width_in = '0;
         height_in = '0;
         objectness = '0;
         best_score = '0;
         best_class = '1;
         expected_dets.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) compare_result();
         if (csr_wr_en) begin
            case (csr_addr)
               drfd_pkg::CSR_NUM_CLASSES:    num_classes = csr_wdata[8:0];
               drfd_pkg::CSR_CONF_THRESHOLD: conf_threshold = csr_wdata[15:0];
               drfd_pkg::CSR_PAD_X:          pad_x = csr_wdata[drfd_pkg::PAD_W-1:0];
               drfd_pkg::CSR_PAD_Y:          pad_y = csr_wdata[drfd_pkg::PAD_W-1:0];
               drfd_pkg::CSR_INV_SCALE:      inv_scale = csr_wdata[drfd_pkg::INV_W-1:0];
               drfd_pkg::CSR_FRAME_WIDTH:    frame_width = csr_wdata[drfd_pkg::DIM_W-1:0];
               drfd_pkg::CSR_FRAME_HEIGHT:   frame_height = csr_wdata[drfd_pkg::DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            decode_element(req_tdata[drfd_pkg::VALUE_W-1:0], req_tuser, req_tlast);
         end
      end
      open_results <= expected_dets.size();
   end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1650;
   localparam int TOTAL_ITEMS = 1800;
   localparam int DRAIN_CYCLES = 8;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [drfd_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [drfd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_wr_en;
   logic [drfd_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [drfd_pkg::CSR_DATA_W-1:0] csr_wdata;

   int                    fail_count;
   int                    open_results;
   int                    items_sent;
   bit                    idle_on;

   int unsigned           cur_nc;
   int unsigned           cur_pad_x;
   int unsigned           cur_pad_y;
   int unsigned           cur_fw;
   int unsigned           cur_fh;

   detection_row_filter_decode_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   detection_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_wr_en    (csr_wr_en),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .open_results (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic int unsigned eff_classes();
      if (cur_nc == 0) return 1;
      if (cur_nc > drfd_pkg::MAX_CLASSES_DEFAULT) return drfd_pkg::MAX_CLASSES_DEFAULT;
      return cur_nc;
   endfunction

   function automatic logic [drfd_pkg::VALUE_W-1:0] pick_coord(input int unsigned span);
      int unsigned lim;
      lim = span * 256;
      if (lim == 0 || lim > 20'hFFFFF) lim = 20'hFFFFF;
      case ($urandom_range(0, 9))
         0:       return drfd_pkg::VALUE_W'($urandom);
         1:       return '0;
         2:       return '1;
         default: return drfd_pkg::VALUE_W'($urandom_range(0, lim));
      endcase
   endfunction

   function automatic logic [drfd_pkg::VALUE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return drfd_pkg::VALUE_W'($urandom);
         2:          return drfd_pkg::VALUE_W'(16'hFFFF);
         3, 4, 5:    return drfd_pkg::VALUE_W'($urandom_range(40000, 65535));
         default:    return drfd_pkg::VALUE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_elem(input logic [drfd_pkg::VALUE_W-1:0] v, input logic fs,
                            input logic fe);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= drfd_pkg::REQ_DATA_W'(v);
      req_tuser <= fs;
      req_tlast <= fe;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The write enable stays high after the edge; the caller drops it after the last write.
   task automatic write_reg(input logic [drfd_pkg::CSR_ADDR_W-1:0] addr,
                            input int unsigned data);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= drfd_pkg::CSR_DATA_W'(data);
      @(posedge clock);
   endtask

   task automatic write_config(input int unsigned nc, input int unsigned thr,
                               input int unsigned px, input int unsigned py,
                               input int unsigned inv, input int unsigned fw,
                               input int unsigned fh);
      wait_quiet();
      write_reg(drfd_pkg::CSR_NUM_CLASSES, nc);
      write_reg(drfd_pkg::CSR_CONF_THRESHOLD, thr);
      write_reg(drfd_pkg::CSR_PAD_X, px);
      write_reg(drfd_pkg::CSR_PAD_Y, py);
      write_reg(drfd_pkg::CSR_INV_SCALE, inv);
      write_reg(drfd_pkg::CSR_FRAME_WIDTH, fw);
      write_reg(drfd_pkg::CSR_FRAME_HEIGHT, fh);
      csr_wr_en <= 1'b0;
      cur_nc = nc;
      cur_pad_x = px;
      cur_pad_y = py;
      cur_fw = fw;
      cur_fh = fh;
   endtask

   task automatic random_config();
      int unsigned nc, thr, px, py, inv, fw, fh;
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
      case ($urandom_range(0, 5))
         0:       thr = 0;
         1:       thr = $urandom_range(0, 65535);
         default: thr = $urandom_range(0, 30000);
      endcase
      px = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
      py = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
      case ($urandom_range(0, 5))
         0:       inv = $urandom_range(1, 24'hFFFFFF);
         1:       inv = 65536;
         default: inv = $urandom_range(32768, 131072);
      endcase
      fw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8191) : $urandom_range(64, 1920);
      fh = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8191) : $urandom_range(64, 1080);
      write_config(nc, thr, px, py, inv, fw, fh);
   endtask

   task automatic send_row(input logic first_row, input logic last_row);
      int unsigned                  len;
      logic [drfd_pkg::VALUE_W-1:0] v;
      logic                         fs;
      logic                         fe;
      len = 5 + eff_classes();
      if ($urandom_range(0, 19) == 0) len = $urandom_range(1, len + 2);
      for (int i = 0; i < len; i++) begin
         case (i)
            0:       v = pick_coord(cur_fw + 2 * cur_pad_x);
            1:       v = pick_coord(cur_fh + 2 * cur_pad_y);
            2:       v = pick_coord(cur_fw);
            3:       v = pick_coord(cur_fh);
            default: v = pick_score();
         endcase
         fs = first_row && (i == 0);
         fe = last_row && (i == len - 1);
         if ($urandom_range(0, 59) == 0) fs = 1'($urandom);
         if ($urandom_range(0, 59) == 0) fe = 1'($urandom);
         send_elem(v, fs, fe);
      end
   endtask

   task automatic send_frame(input int unsigned rows);
      for (int r = 0; r < rows; r++) send_row(r == 0, r == rows - 1);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_wr_en = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      items_sent = 0;
      idle_on = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_config(2, 0, 0, 0, 65536, 640, 480);
      send_elem(20'd25600, 1'b1, 1'b0);
      send_elem(20'd20480, 1'b0, 1'b0);
      send_elem(20'd10240, 1'b0, 1'b0);
      send_elem(20'd7680, 1'b0, 1'b0);
      send_elem(20'hFFFFF, 1'b0, 1'b0);
      send_elem(20'd0, 1'b0, 1'b0);
      send_elem(20'd0, 1'b0, 1'b0);
      send_elem(20'd0, 1'b0, 1'b0);
      send_elem(20'd0, 1'b0, 1'b0);
      send_elem(20'hFFFFF, 1'b0, 1'b0);
      send_elem(20'hFFFFF, 1'b0, 1'b0);
      send_elem(20'd40000, 1'b0, 1'b0);
      send_elem(20'hFFFFF, 1'b0, 1'b0);
      send_elem(20'd65535, 1'b0, 1'b1);
      send_elem(20'd1280, 1'b1, 1'b0);
      send_elem(20'd2560, 1'b0, 1'b0);
      send_elem(20'd3840, 1'b0, 1'b0);
      send_elem(20'd5120, 1'b1, 1'b0);
      send_elem(20'd6400, 1'b0, 1'b0);
      send_elem(20'hFFFFF, 1'b0, 1'b1);

      write_config(4, 0, 0, 0, 65536, 640, 480);
      send_elem(20'd51200, 1'b1, 1'b0);
      send_elem(20'd38400, 1'b0, 1'b0);
      send_elem(20'd12800, 1'b0, 1'b0);
      send_elem(20'd12800, 1'b0, 1'b0);
      send_elem(20'd60000, 1'b0, 1'b0);
      send_elem(20'd30000, 1'b0, 1'b0);
      send_elem(20'd50000, 1'b0, 1'b0);
      wait_quiet();
      write_reg(drfd_pkg::CSR_NUM_CLASSES, 1);
      csr_wr_en <= 1'b0;
      cur_nc = 1;
      send_elem(20'd55000, 1'b0, 1'b0);

      write_config(0, 65535, 4095, 4095, 24'hFFFFFF, 8191, 8191);
      repeat (2) send_frame(3);
      write_config(1, 0, 0, 0, 1, 1, 1);
      repeat (2) send_frame(3);
      write_config(256, 0, 0, 0, 65536, 640, 480);
      send_frame(1);
      write_config(511, 100, 0, 0, 65536, 0, 8191);
      send_frame(1);

      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         random_config();
         repeat ($urandom_range(1, 4)) send_frame($urandom_range(1, 4));
      end

      idle_on = 1'b0;
      random_config();
      while (items_sent < TOTAL_ITEMS) send_frame($urandom_range(1, 4));

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
